FILE: sv/skm_pkg.sv
package skm_pkg;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_FEED    = 2'd2;

    localparam logic [7:0] CH_CR = 8'd13;

    localparam int CFG_W = 5;
    localparam int OUT_W = 5;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] keyword_slot;
        logic [3:0] char_position;
        logic [7:0] char_value;
    } in_beat_t;

    typedef struct packed {
        logic             keep_going;
        logic             matched;
        logic [OUT_W-1:0] current_keyword;
        logic [OUT_W-1:0] matched_length;
    } out_beat_t;

    typedef struct packed {
        logic accept;
        logic ptr_inc;
        logic off_inc;
        logic set_match;
        logic set_keep;
        logic idx_clr;
        logic idx_inc;
        logic cmp_sel;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       ptr_done;
        logic       k_hit;
        logic       is_cr;
        logic       k_zero;
        logic       last_kw;
        logic       off_zero;
        logic       cmp_diff;
        logic       idx_last;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: sv/skm_ram.sv
module skm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: sv/skm_ctrl.sv
module skm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  skm_pkg::dp_stat_t stat,
    output skm_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_TEST,
        ST_CMP_RD,
        ST_CMP,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.accept = 1'b1;
                    if (stat.command == skm_pkg::CMD_FEED && !stat.ptr_done) begin
                        state_next = ST_TEST;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (stat.k_hit) begin
                    cmd.off_inc  = 1'b1;
                    cmd.set_keep = 1'b1;
                    state_next   = ST_RESP;
                end else if (stat.is_cr) begin
                    cmd.set_keep = 1'b1;
                    state_next   = ST_RESP;
                end else if (stat.k_zero) begin
                    cmd.set_match = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    if (stat.last_kw) begin
                        state_next = ST_RESP;
                    end else if (stat.off_zero) begin
                        state_next = ST_FETCH;
                    end else begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_CMP_RD;
                    end
                end
            end
            ST_CMP_RD: begin
                cmd.cmp_sel = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                if (stat.cmp_diff) begin
                    state_next = ST_RESP;
                end else if (stat.idx_last) begin
                    state_next = ST_FETCH;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CMP_RD;
                end
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

FILE: sv/skm_datapath.sv
module skm_datapath #(
    parameter int NUM_KEYWORDS = 16,
    parameter int KEY_LEN      = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  skm_pkg::in_beat_t            s_data,
    input  logic                         cfg_wr_en,
    input  logic [skm_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         m_ready,
    output logic                         m_valid,
    output skm_pkg::out_beat_t           m_data,
    input  skm_pkg::dp_cmd_t             cmd,
    output skm_pkg::dp_stat_t            stat
);

    localparam int PW    = $clog2(NUM_KEYWORDS + 1);
    localparam int OW    = $clog2(KEY_LEN + 1);
    localparam int CLW   = $clog2(KEY_LEN);
    localparam int DEPTH = NUM_KEYWORDS * KEY_LEN;
    localparam int AW    = $clog2(DEPTH);

    logic [PW-1:0]      ptr_reg, count_reg;
    logic [OW-1:0]      off_reg;
    logic [CLW-1:0]     idx_reg;
    logic               match_reg, keep_reg;
    logic [7:0]         char_reg;
    logic               m_valid_reg;
    skm_pkg::out_beat_t m_data_reg;

    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [7:0]    rd_data_a, rd_data_b, k_byte;
    logic          wr_en, off_end, in_range;
    int            row_cur, col_cur;

    function automatic logic [AW-1:0] addr_of(input int row, input int col);
        return AW'(row * KEY_LEN + col);
    endfunction

    assign off_end  = (off_reg == OW'(KEY_LEN));
    assign in_range = (int'(s_data.keyword_slot) < NUM_KEYWORDS) &&
                      (int'(s_data.char_position) < KEY_LEN);
    assign wr_en    = cmd.accept && (s_data.command == skm_pkg::CMD_LOAD) && in_range;
    assign wr_addr  = addr_of(int'(s_data.keyword_slot), int'(s_data.char_position));

    always_comb begin
        row_cur = stat.ptr_done ? 0 : int'(ptr_reg);
        col_cur = off_end ? 0 : int'(off_reg);
        if (cmd.cmp_sel) begin
            rd_addr_a = addr_of(int'(ptr_reg) - 1, int'(idx_reg));
        end else begin
            rd_addr_a = addr_of(row_cur, col_cur);
        end
        rd_addr_b = addr_of(row_cur, int'(idx_reg));
    end

    skm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_table (
        .clk       (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_data.char_value),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign k_byte = off_end ? 8'd0 : rd_data_a;

    always_comb begin
        stat          = '0;
        stat.command  = s_data.command;
        stat.ptr_done = (ptr_reg >= count_reg);
        stat.k_zero   = (k_byte == 8'd0);
        stat.k_hit    = (k_byte != 8'd0) && (k_byte == char_reg);
        stat.is_cr    = (char_reg == skm_pkg::CH_CR);
        stat.last_kw  = ({1'b0, ptr_reg} + (PW + 1)'(1)) >= {1'b0, count_reg};
        stat.off_zero = (off_reg == '0);
        stat.cmp_diff = (rd_data_a != rd_data_b);
        stat.idx_last = ((OW'(idx_reg) + OW'(1)) == off_reg);
        stat.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            off_reg     <= '0;
            match_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (int'(cfg_wr_data) > NUM_KEYWORDS) begin
                    count_reg <= PW'(NUM_KEYWORDS);
                end else begin
                    count_reg <= PW'(cfg_wr_data);
                end
            end
            if (cmd.accept && s_data.command == skm_pkg::CMD_RESTART) begin
                ptr_reg   <= '0;
                off_reg   <= '0;
                match_reg <= 1'b0;
            end
            if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + PW'(1);
            end
            if (cmd.off_inc) begin
                off_reg <= off_reg + OW'(1);
            end
            if (cmd.set_match) begin
                match_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= s_data.char_value;
            keep_reg <= 1'b0;
        end else if (cmd.set_keep) begin
            keep_reg <= 1'b1;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CLW'(1);
        end
        if (cmd.out_load) begin
            m_data_reg.keep_going      <= keep_reg;
            m_data_reg.matched         <= match_reg;
            m_data_reg.current_keyword <= skm_pkg::OUT_W'(ptr_reg);
            m_data_reg.matched_length  <= skm_pkg::OUT_W'(off_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/sorted_keyword_stream_matcher_top.sv
// Matches a byte stream against a sorted table of zero-terminated keywords.
// The input channel (s_valid, s_ready, s_data) carries one command per beat:
// load a table byte, restart the matcher, or feed a stream byte. Every input
// beat yields exactly one result beat on m_valid, m_ready, m_data, reporting
// keep_going, the match flag, the current keyword index and the matched length.
// The keyword count is written through cfg_wr_en and cfg_wr_data while idle.
// A load, restart or unused command goes straight to the response state.
// A feed that resolves on the current keyword ends in the test state; each further
// keyword it tests is reached via the compare-read and compare states, once
// per prefix byte checked against the previous keyword, then the fetch state.
// One item is handled at a time; the table memory reads two bytes per cycle.
// The result sits in an output register, so the next beat is accepted while
// an earlier result still waits; if the receiver stalls, the block stops
// after finishing that next item until the register drains.
// Reset clears the keyword pointer, position, match flag and keyword count;
// the table contents are undefined until loaded and survive a restart.
module sorted_keyword_stream_matcher_top #(
    parameter int NUM_KEYWORDS = 16,
    parameter int KEY_LEN      = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  skm_pkg::in_beat_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output skm_pkg::out_beat_t        m_data,
    input  logic                      cfg_wr_en,
    input  logic [skm_pkg::CFG_W-1:0] cfg_wr_data
);

    skm_pkg::dp_cmd_t  cmd;
    skm_pkg::dp_stat_t stat;

    skm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    skm_datapath #(
        .NUM_KEYWORDS (NUM_KEYWORDS),
        .KEY_LEN      (KEY_LEN)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

FILE: sv/skm_checker.sv
module skm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input skm_pkg::out_beat_t m_data
);

    logic [1:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input accepted while previous item still in work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // Every result beat belongs to an accepted input beat.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> pend_reg != 2'd0)
        else $error("result beat without an input beat");

    // At most one item in work plus one result waiting.
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 2'd2)
        else $error("too many items outstanding");

endmodule

bind sorted_keyword_stream_matcher_top skm_checker u_skm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
